// ----- hw/rtl/bitmap_id_allocator_core_defines.svh -----
// Assertion macros shared by the bitmap ID allocator checkers.
`ifndef BITMAP_ID_ALLOCATOR_CORE_DEFINES_SVH
`define BITMAP_ID_ALLOCATOR_CORE_DEFINES_SVH

// Clocked assertion, switched off while reset is high.
`define BIA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Clocked assertion that also holds across reset.
`define BIA_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

// ----- hw/rtl/bia_pkg.sv -----
// Types, constants and helper functions of the bitmap ID allocator.
`timescale 1ns / 1ps

package bia_pkg;

   localparam int MAX_IDS    = 256;
   localparam int WORD_BITS  = 32;
   localparam int WORD_COUNT = (MAX_IDS + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_IDX_W = $clog2(WORD_COUNT);
   localparam int BIT_IDX_W  = $clog2(WORD_BITS);
   localparam int ID_W       = $clog2(MAX_IDS);
   localparam int COUNT_W    = ID_W + 1;
   localparam int TARGET_W   = 9;

   // csr port: one 32-bit register per 4-byte slot
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_ID_COUNT = CSR_IDX_W'(0);
   localparam logic [COUNT_W-1:0]   ID_COUNT_RESET   = COUNT_W'(MAX_IDS);

   typedef enum logic {
      CMD_ALLOC,
      CMD_FREE
   } bia_cmd_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_NOFREE,
      ST_INVALID
   } bia_status_type;

   typedef enum logic {
      S_IDLE,
      S_CHECK
   } bia_state_type;

   typedef struct packed {
      logic                  rd_en;
      logic [WORD_IDX_W-1:0] rd_addr;
      logic                  wr_en;
      logic [WORD_IDX_W-1:0] wr_addr;
      logic [WORD_BITS-1:0]  wr_data;
   } bia_ram_req_type;

   // lowest clear bit of a bitmap word (0 when the word is full)
   function automatic logic [BIT_IDX_W-1:0] first_zero(input logic [WORD_BITS-1:0] word);
      logic [BIT_IDX_W-1:0] pos;
      pos = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!word[i]) pos = BIT_IDX_W'(i);
      end
      return pos;
   endfunction

endpackage

// ----- hw/rtl/bia_channel_if.sv -----
// Request and response channel interfaces of the bitmap ID allocator.
`timescale 1ns / 1ps

interface bia_req_if
   import bia_pkg::*;
();
   logic                valid;
   logic                ready;
   logic                cmd;
   logic [TARGET_W-1:0] free_target;

   modport source (output valid, cmd, free_target, input ready);
   modport sink   (input valid, cmd, free_target, output ready);
endinterface

interface bia_rsp_if
   import bia_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic [ID_W-1:0]    granted_id;
   logic [COUNT_W-1:0] used_count;
   logic               is_empty;

   modport source (output valid, status, granted_id, used_count, is_empty, input ready);
   modport sink   (input valid, status, granted_id, used_count, is_empty, output ready);
endinterface

// ----- hw/rtl/bia_bitmap_ram.sv -----
// Bitmap word memory with a registered read and per-word valid bits.
`timescale 1ns / 1ps

module bia_bitmap_ram
   import bia_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  bia_ram_req_type      ram_req,
   output logic [WORD_BITS-1:0] rd_data
);

   logic [WORD_BITS-1:0]  mem [WORD_COUNT];
   logic [WORD_BITS-1:0]  q_ff;
   logic                  q_valid_ff;
   logic [WORD_COUNT-1:0] valid_ff;
   logic [WORD_COUNT-1:0] valid_in;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) mem[ram_req.wr_addr] <= ram_req.wr_data;
      if (ram_req.rd_en) q_ff <= mem[ram_req.rd_addr];
   end

   // a word never written since reset reads as all free
   always_comb begin
      valid_in = valid_ff;
      if (ram_req.wr_en) valid_in[ram_req.wr_addr] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         q_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (ram_req.rd_en) q_valid_ff <= valid_ff[ram_req.rd_addr];
      end
   end

   assign rd_data = q_valid_ff ? q_ff : '0;

endmodule

// ----- hw/rtl/bia_csr.sv -----
// APB register block holding the ID count and the derived ID limit.
`timescale 1ns / 1ps

module bia_csr
   import bia_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   input  logic                  count_zero,
   output logic [COUNT_W-1:0]    id_limit
);

   logic [COUNT_W-1:0]   id_count_ff;
   logic [COUNT_W-1:0]   id_count_in;
   logic [CSR_IDX_W-1:0] reg_idx;
   logic                 wr_hit;

   assign pready  = 1'b1;
   assign reg_idx = paddr[CSR_ADDR_W-1:2];

   // writes are dropped while any ID is out, so every marked ID stays below the limit
   assign wr_hit = psel && penable && pwrite && pready
                   && (reg_idx == CSR_IDX_ID_COUNT) && count_zero;

   assign id_count_in = wr_hit ? pwdata[COUNT_W-1:0] : id_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         id_count_ff <= ID_COUNT_RESET;
      end else begin
         id_count_ff <= id_count_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         CSR_IDX_ID_COUNT: prdata = CSR_DATA_W'(id_count_ff);
         default:          prdata = '0;
      endcase
   end

   assign id_limit = (id_count_ff > COUNT_W'(MAX_IDS)) ? COUNT_W'(MAX_IDS) : id_count_ff;

endmodule

// ----- hw/rtl/bia_ctrl.sv -----
// Sequencer: reads, scans and writes back bitmap words, keeps the in-use count.
`timescale 1ns / 1ps

module bia_ctrl
   import bia_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   bia_req_if.sink              req,
   bia_rsp_if.source            rsp,
   input  logic [COUNT_W-1:0]   id_limit,
   output logic                 count_zero,
   output bia_ram_req_type      ram_req,
   input  logic [WORD_BITS-1:0] rd_data
);

   bia_state_type         state_ff, state_in;
   bia_cmd_type           cmd_ff, cmd_in;
   logic [ID_W-1:0]       target_ff, target_in;
   logic                  pre_fail_ff, pre_fail_in;
   bia_status_type        pre_status_ff, pre_status_in;
   logic [WORD_IDX_W-1:0] word_idx_ff, word_idx_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   bia_status_type        rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]       rsp_id_ff, rsp_id_in;

   logic                  accept;
   logic                  rsp_free;
   logic [BIT_IDX_W-1:0]  bit_sel;
   logic [WORD_BITS-1:0]  bit_mask;

   assign req.ready  = (state_ff == S_IDLE);
   assign accept     = req.valid && req.ready;
   assign rsp_free   = !rsp_valid_ff || rsp.ready;
   assign count_zero = (count_ff == '0);

   assign bit_sel  = (cmd_ff == CMD_ALLOC) ? first_zero(rd_data) : target_ff[BIT_IDX_W-1:0];
   assign bit_mask = WORD_BITS'(1) << bit_sel;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      target_in     = target_ff;
      pre_fail_in   = pre_fail_ff;
      pre_status_in = pre_status_ff;
      word_idx_in   = word_idx_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      ram_req       = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in    = bia_cmd_type'(req.cmd);
               target_in = req.free_target[ID_W-1:0];
               if (req.cmd == CMD_FREE) begin
                  word_idx_in   = req.free_target[ID_W-1:BIT_IDX_W];
                  pre_fail_in   = (req.free_target >= TARGET_W'(id_limit));
                  pre_status_in = ST_INVALID;
               end else begin
                  word_idx_in   = '0;
                  pre_fail_in   = (count_ff >= id_limit);
                  pre_status_in = ST_NOFREE;
               end
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = word_idx_in;
               state_in        = S_CHECK;
            end
         end

         S_CHECK: begin
            if (pre_fail_ff) begin
               if (rsp_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = pre_status_ff;
                  rsp_id_in     = '0;
                  state_in      = S_IDLE;
               end
            end else if (cmd_ff == CMD_ALLOC && (&rd_data)
                         && word_idx_ff != WORD_IDX_W'(WORD_COUNT - 1)) begin
               // full word: fetch the next one, data is back next cycle
               word_idx_in     = word_idx_ff + WORD_IDX_W'(1);
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = word_idx_in;
            end else if ((cmd_ff == CMD_ALLOC && (&rd_data))
                         || (cmd_ff == CMD_FREE && (rd_data & bit_mask) == '0)) begin
               if (rsp_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = (cmd_ff == CMD_ALLOC) ? ST_NOFREE : ST_INVALID;
                  rsp_id_in     = '0;
                  state_in      = S_IDLE;
               end
            end else if (rsp_free) begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = word_idx_ff;
               rsp_valid_in    = 1'b1;
               rsp_status_in   = ST_OK;
               state_in        = S_IDLE;
               if (cmd_ff == CMD_ALLOC) begin
                  ram_req.wr_data = rd_data | bit_mask;
                  count_in        = count_ff + COUNT_W'(1);
                  rsp_id_in       = {word_idx_ff, bit_sel};
               end else begin
                  ram_req.wr_data = rd_data & ~bit_mask;
                  count_in        = count_ff - COUNT_W'(1);
                  rsp_id_in       = '0;
               end
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      target_ff     <= target_in;
      pre_fail_ff   <= pre_fail_in;
      pre_status_ff <= pre_status_in;
      word_idx_ff   <= word_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
   end

   // count only moves when a word is loaded into the output register
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.status     = rsp_status_ff;
   assign rsp.granted_id = rsp_id_ff;
   assign rsp.used_count = count_ff;
   assign rsp.is_empty   = count_zero;

endmodule

// ----- hw/rtl/bitmap_id_allocator_core.sv -----
// Top level of the bitmap ID allocator: register block, sequencer and bitmap memory.
//
// Request channel (req): one word per operation, cmd 0 allocates the lowest free
//   ID below the configured limit, cmd 1 frees free_target. Accepted when
//   req.valid and req.ready are both high.
// Response channel (rsp): one word per request, in order: status, granted_id,
//   used_count (after the operation) and is_empty.
// CSR port (APB style): id_count at byte address 0. A write is dropped while
//   any ID is allocated. Values above 256 act as 256.
// Sequence: the first bitmap word is read in the cycle the request is taken.
//   Each following cycle checks one 32-bit word; a free or a rejected request
//   is decided on the first word, an allocate scans one word per cycle until
//   it finds a clear bit. Only one request is in flight at a time; the scan
//   runs over the bitmap memory's single read port.
// Stall: the response sits in an output register; the next request is taken
//   while it waits, and a finished operation holds in the check stage until
//   the register is free.
// Reset: synchronous, active high. All IDs become free at once (per-word valid
//   bits), the count clears and id_count returns to 256. No clearing pass.
`timescale 1ns / 1ps

module bitmap_id_allocator_core
   import bia_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   bia_req_if.sink               req,
   bia_rsp_if.source             rsp,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [COUNT_W-1:0]   id_limit;
   logic                 count_zero;
   bia_ram_req_type      ram_req;
   logic [WORD_BITS-1:0] rd_data;

   // id_count register and saturated limit
   bia_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (csr_psel),
      .penable    (csr_penable),
      .pwrite     (csr_pwrite),
      .paddr      (csr_paddr),
      .pwdata     (csr_pwdata),
      .prdata     (csr_prdata),
      .pready     (csr_pready),
      .count_zero (count_zero),
      .id_limit   (id_limit)
   );

   // read / scan / write-back sequencer; owns the in-use count and output register
   bia_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .rsp        (rsp),
      .id_limit   (id_limit),
      .count_zero (count_zero),
      .ram_req    (ram_req),
      .rd_data    (rd_data)
   );

   // eight 32-bit bitmap words, one read port and one write port
   bia_bitmap_ram u_ram (
      .clock   (clock),
      .reset   (reset),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

endmodule

// ----- hw/rtl/bia_checker.sv -----
// Port-level checker for the bitmap ID allocator and its bind.
`timescale 1ns / 1ps
`include "bitmap_id_allocator_core_defines.svh"

module bia_checker
   import bia_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [1:0]         rsp_status,
   input logic [ID_W-1:0]    rsp_granted_id,
   input logic [COUNT_W-1:0] rsp_used_count,
   input logic               rsp_is_empty
);

   `BIA_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_granted_id) && $stable(rsp_used_count), "response word changed while stalled")

   `BIA_ASSERT(a_one_in_flight, req_valid && req_ready |=> !req_ready, "request taken while one is in flight")

   `BIA_ASSERT(a_reject_fields, rsp_valid && rsp_status != 2'(ST_OK) |-> rsp_granted_id == '0 && rsp_is_empty == (rsp_used_count == '0), "rejected response carries an ID or a bad empty flag")

   `BIA_ASSERT_RST(a_reset_quiet, $past(reset) |-> !rsp_valid, "response valid right after reset")

endmodule

bind bitmap_id_allocator_core bia_checker u_bia_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_status     (rsp.status),
   .rsp_granted_id (rsp.granted_id),
   .rsp_used_count (rsp.used_count),
   .rsp_is_empty   (rsp.is_empty)
);

// ----- verif/tb_bitmap_id_allocator_core.sv -----
// Self-checking testbench for bitmap_id_allocator_core: ID pool prediction and response checks.
`timescale 1ns / 1ps

module tb_bitmap_id_allocator_core;
   import bia_pkg::*;

   // one request word as the driver sends it
   typedef struct packed {
      bia_cmd_type         cmd;
      logic [TARGET_W-1:0] target;
   } req_word_type;

   // one response word as the pool should report it
   typedef struct packed {
      bia_status_type     status;
      logic [ID_W-1:0]    granted;
      logic [COUNT_W-1:0] used;
      logic               empty;
   } rsp_word_type;

   // ID pool state: usage bitmap, in-use count and the id_count register
   typedef struct packed {
      logic [MAX_IDS-1:0] used_map;
      logic [COUNT_W-1:0] in_use;
      logic [COUNT_W-1:0] id_count;
   } id_pool_type;

   localparam int RANDOM_WORDS = 1600;
   localparam int MAX_GAP      = 11;
   localparam int HOLD_CYCLES  = 400;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   bia_req_if req_if ();
   bia_rsp_if rsp_if ();

   bitmap_id_allocator_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // words waiting to be sent, and responses owed by the block
   req_word_type   pending_ops[$];
   rsp_word_type   owed_rsp[$];

   // live pool follows accepted words; plan pool follows the generator
   id_pool_type    live_pool;
   id_pool_type    plan_pool;

   int unsigned mismatches;
   int unsigned words_sent;
   int unsigned random_words;
   int unsigned req_gap;
   int unsigned rsp_gap;
   bit          req_calm;
   bit          rsp_calm;
   logic        hold_rsp;

   // 10 ns clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // --------------------------------------------------------------------
   // Pool predictor
   // --------------------------------------------------------------------

   // usable IDs: the register saturates at MAX_IDS
   function automatic int unsigned pool_limit(input id_pool_type pool);
      return (pool.id_count > MAX_IDS) ? MAX_IDS : int'(pool.id_count);
   endfunction

   function automatic rsp_word_type predict_op(inout id_pool_type pool, input req_word_type w);
      rsp_word_type r;
      int unsigned  lim;
      lim       = pool_limit(pool);
      r.status  = ST_OK;
      r.granted = '0;
      if (w.cmd == CMD_ALLOC) begin
         // lowest clear bit below the limit, else no free ID
         r.status = ST_NOFREE;
         if (pool.in_use < lim) begin
            for (int i = 0; i < lim; i++) begin
               if (!pool.used_map[i]) begin
                  pool.used_map[i] = 1'b1;
                  pool.in_use      = pool.in_use + 1'b1;
                  r.granted        = ID_W'(i);
                  r.status         = ST_OK;
                  break;
               end
            end
         end
      end else begin
         // out of range or not marked: rejected, nothing changes
         if (w.target >= lim) begin
            r.status = ST_INVALID;
         end else if (!pool.used_map[w.target]) begin
            r.status = ST_INVALID;
         end else begin
            pool.used_map[w.target] = 1'b0;
            if (pool.in_use != 0) pool.in_use = pool.in_use - 1'b1;
         end
      end
      r.used  = pool.in_use;
      r.empty = (pool.in_use == 0);
      return r;
   endfunction

   // register write is dropped while any ID is out
   function automatic void latch_id_count(inout id_pool_type pool,
                                          input logic [CSR_DATA_W-1:0] v);
      if (pool.in_use == 0) pool.id_count = v[COUNT_W-1:0];
   endfunction

   function automatic void clear_pool(inout id_pool_type pool);
      pool.used_map = '0;
      pool.in_use   = '0;
      pool.id_count = ID_COUNT_RESET;
   endfunction

   // some marked ID of the plan pool, searched from a random start
   function automatic logic [TARGET_W-1:0] pick_marked(input id_pool_type pool);
      int unsigned start;
      int unsigned id;
      start = $urandom_range(0, MAX_IDS - 1);
      for (int i = 0; i < MAX_IDS; i++) begin
         id = (start + i) % MAX_IDS;
         if (pool.used_map[id]) return TARGET_W'(id);
      end
      return TARGET_W'(start);
   endfunction

   // idle gap per word: none in calm stretches, else 0..MAX_GAP
   function automatic int unsigned draw_gap(input bit calm);
      return calm ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   // --------------------------------------------------------------------
   // Request driver
   // --------------------------------------------------------------------
   always @(posedge clock) begin
      req_word_type w;
      if (reset) begin
         req_if.valid       <= 1'b0;
         req_if.cmd         <= CMD_ALLOC;
         req_if.free_target <= '0;
         req_gap            <= 0;
      end else begin
         // accepted word: predict its response now, in accept order
         if (req_if.valid && req_if.ready) begin
            w.cmd    = bia_cmd_type'(req_if.cmd);
            w.target = req_if.free_target;
            owed_rsp.push_back(predict_op(live_pool, w));
            words_sent++;
            if ($urandom_range(0, 63) == 0) req_calm = !req_calm;
         end
         // a word still waiting on ready holds; otherwise move on
         if (!(req_if.valid && !req_if.ready)) begin
            if (req_gap != 0) begin
               req_if.valid <= 1'b0;
               req_gap      <= req_gap - 1;
            end else if (pending_ops.size() != 0) begin
               w = pending_ops.pop_front();
               req_if.valid       <= 1'b1;
               req_if.cmd         <= w.cmd;
               req_if.free_target <= w.target;
               req_gap            <= draw_gap(req_calm);
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // --------------------------------------------------------------------
   // Response monitor and checker
   // --------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_word_type e;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (owed_rsp.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected word: status %0d id %0d used %0d empty %0d",
                           $realtime, rsp_if.status, rsp_if.granted_id, rsp_if.used_count,
                           rsp_if.is_empty);
            end else begin
               e = owed_rsp.pop_front();
               if (rsp_if.status !== e.status || rsp_if.granted_id !== e.granted ||
                   rsp_if.used_count !== e.used || rsp_if.is_empty !== e.empty) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: mismatch: exp status %0d id %0d used %0d empty %0d,",
                              $realtime, e.status, e.granted, e.used, e.empty,
                              " got status %0d id %0d used %0d empty %0d",
                              rsp_if.status, rsp_if.granted_id, rsp_if.used_count,
                              rsp_if.is_empty);
               end
            end
            rsp_gap = draw_gap(rsp_calm);
            if ($urandom_range(0, 63) == 0) rsp_calm = !rsp_calm;
         end
         if (rsp_gap != 0) begin
            rsp_if.ready <= 1'b0;
            rsp_gap--;
         end else begin
            rsp_if.ready <= !hold_rsp;
         end
      end
   end

   // Long response hold-offs while the sender keeps offering words,
   // so the output register and check stage back up into req.ready.
   initial begin
      hold_rsp = 1'b0;
      wait (words_sent >= 300);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
      wait (words_sent >= 1100);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // Hard stop well past the slowest legal run.
   initial begin
      #5_000_000;
      $display("bitmap_id_allocator_core test failed");
      $finish;
   end

   // --------------------------------------------------------------------
   // Stimulus
   // --------------------------------------------------------------------

   // queue one word; plan pool tracks what it will do
   task automatic queue_op(input bia_cmd_type cmd, input logic [TARGET_W-1:0] target);
      req_word_type w;
      rsp_word_type unused;
      w.cmd    = cmd;
      w.target = target;
      unused   = predict_op(plan_pool, w);
      pending_ops.push_back(w);
   endtask

   // block idle: nothing queued, nothing on the wire, nothing owed
   task automatic wait_quiet();
      do @(negedge clock);
      while (pending_ops.size() != 0 || req_if.valid || owed_rsp.size() != 0);
   endtask

   // APB write of id_count, only once the block is idle
   task automatic write_id_count(input logic [CSR_DATA_W-1:0] v);
      wait_quiet();
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {CSR_IDX_ID_COUNT, 2'b00};
      csr_pwdata  <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (!csr_pready);
      // register takes the value at this edge
      latch_id_count(live_pool, v);
      latch_id_count(plan_pool, v);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // release every ID the plan pool holds
   task automatic drain_pool();
      while (plan_pool.in_use != 0) begin
         queue_op(CMD_FREE, pick_marked(plan_pool));
         random_words++;
      end
   endtask

   initial begin
      int unsigned phase_len;
      int unsigned alloc_pct;
      int unsigned roll;
      logic [CSR_DATA_W-1:0] setting;

      reset       = 1'b1;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      req_if.valid       = 1'b0;
      req_if.cmd         = CMD_ALLOC;
      req_if.free_target = '0;
      rsp_if.ready       = 1'b0;
      mismatches   = 0;
      words_sent   = 0;
      random_words = 0;
      req_gap      = 0;
      rsp_gap      = 0;
      req_calm     = 1'b0;
      rsp_calm     = 1'b0;
      clear_pool(live_pool);
      clear_pool(plan_pool);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: first allocs, double free, out-of-range and unmarked frees
      queue_op(CMD_ALLOC, '0);
      queue_op(CMD_ALLOC, '1);
      queue_op(CMD_ALLOC, '0);
      queue_op(CMD_FREE, 9'd1);
      queue_op(CMD_FREE, 9'd1);
      queue_op(CMD_FREE, 9'd511);
      queue_op(CMD_FREE, 9'd256);
      queue_op(CMD_FREE, 9'd3);
      queue_op(CMD_ALLOC, '0);          // reuses the hole at 1
      // write while IDs are out: dropped
      write_id_count(32'd5);
      queue_op(CMD_FREE, 9'd0);
      queue_op(CMD_FREE, 9'd1);
      queue_op(CMD_FREE, 9'd2);
      // zero IDs: nothing can be handed out or freed
      write_id_count(32'd0);
      queue_op(CMD_ALLOC, '0);
      queue_op(CMD_FREE, 9'd0);
      // single ID: second alloc finds the pool full
      write_id_count(32'd1);
      queue_op(CMD_ALLOC, '0);
      queue_op(CMD_ALLOC, '0);
      queue_op(CMD_FREE, 9'd1);
      queue_op(CMD_FREE, 9'd0);
      queue_op(CMD_FREE, 9'd0);
      // top of the register range saturates at MAX_IDS
      write_id_count(32'd511);
      queue_op(CMD_ALLOC, '0);
      queue_op(CMD_FREE, 9'd255);
      queue_op(CMD_FREE, 9'd0);

      // random phases, each under its own id_count setting
      while (random_words < RANDOM_WORDS) begin
         roll = $urandom_range(0, 9);
         case (roll)
            0: setting = 32'd1;
            1: setting = 32'd2;
            2: setting = 32'd32;
            3: setting = 32'd33;
            4: setting = 32'd256;
            5: setting = 32'd0;
            6: setting = 32'd511;
            7: setting = $urandom_range(257, 511);
            default: setting = $urandom_range(1, 256);
         endcase
         // upper pwdata bits are don't-care; toggle them too
         setting[31:COUNT_W] = $urandom();
         write_id_count(setting);

         // sometimes run the pool to full and one past
         if ($urandom_range(0, 3) == 0) begin
            for (int i = 0; i <= pool_limit(plan_pool); i++) begin
               queue_op(CMD_ALLOC, TARGET_W'($urandom()));
               random_words++;
            end
         end

         phase_len = $urandom_range(20, 150);
         alloc_pct = $urandom_range(30, 80);
         for (int i = 0; i < phase_len; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < alloc_pct)
               queue_op(CMD_ALLOC, TARGET_W'($urandom()));
            else if (roll < 92 && plan_pool.in_use != 0)
               queue_op(CMD_FREE, pick_marked(plan_pool));
            else
               queue_op(CMD_FREE, TARGET_W'($urandom()));   // noise, mostly rejected
            random_words++;
         end

         // a write while IDs are out must be dropped
         if (plan_pool.in_use != 0 && $urandom_range(0, 2) == 0)
            write_id_count($urandom_range(0, 511));
         drain_pool();
      end

      // all words out; wait for the last responses, then a short tail
      wait_quiet();
      repeat (30) @(posedge clock);
      if (mismatches == 0 && owed_rsp.size() == 0) begin
         $display("bitmap_id_allocator_core test passed");
      end else begin
         $display("bitmap_id_allocator_core test failed");
      end
      $finish;
   end

endmodule
